// ===== design/text_console_port_device_top_assert.svh =====
// assertion macros used by the checker file
`ifndef TEXT_CONSOLE_PORT_DEVICE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_PORT_DEVICE_TOP_ASSERT_SVH

// property checked outside reset
`define TCPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TCPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tcpd_pkg.sv =====
package tcpd_pkg;

  // screen geometry
  localparam int Cols   = 80;
  localparam int Rows   = 25;
  localparam int Cells  = Cols * Rows;
  localparam int ColW   = $clog2(Cols);
  localparam int RowW   = $clog2(Rows);
  localparam int AddrW  = $clog2(Cells);
  localparam int CellW  = 16;

  // command queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // tab expands to this many spaces
  localparam int TabLen = 4;
  localparam int TabW   = $clog2(TabLen + 1);

  // port numbers
  localparam logic [15:0] PortCtrl = 16'h04E8;
  localparam logic [15:0] PortData = 16'h04E9;
  localparam logic [15:0] PortCol  = 16'h04EA;
  localparam logic [15:0] PortRow  = 16'h04EB;

  // character codes
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLineFeed  = 8'h0A;
  localparam logic [7:0] ChCarriage  = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDelete    = 8'h7F;

  // read value of an unknown port
  localparam logic [15:0] ReadMiss = 16'hFFFF;

  // blank cell: colour 0, space
  localparam logic [CellW-1:0] BlankCell = {8'h00, ChSpace};

  typedef enum logic [3:0] {
    CMD_MISS,
    CMD_NOP,
    CMD_RD_DATA,
    CMD_RD_COL,
    CMD_RD_ROW,
    CMD_SET_COL,
    CMD_SET_ROW,
    CMD_BS,
    CMD_TAB,
    CMD_LF,
    CMD_CR,
    CMD_DRAW
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic       is_read;
    logic       is_byte;
    logic [7:0] value;
    logic [7:0] colour;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_TAB,
    ST_CLEAR
  } st_e;

endpackage

// ===== design/text_console_port_device_top.sv =====
// Text console on four I/O ports (control, data, cursor column, cursor row).
// Input channel: in_valid_i / in_stall_o carry one bus access per
// transaction (opcode_i, byte_access_i, port_address_i, write_data_i).
// Output channel: out_valid_o / out_stall_i carry exactly one result per
// access (read_data_o, port_hit_o), in order.
// Accesses go into a two-entry command queue, so the input side keeps
// taking transactions while a result waits on a stalled receiver; once the
// queue is full, in_stall_o rises.
// Throughput: one access per cycle for cursor, control and plain writes,
// while the receiver takes results; a data read holds the executor in
// ST_READ before the next access. A line feed, or a character that wraps
// the line, clears the new row one cell per cycle; a tab adds four cell
// writes. The single write port of the cell memory sets these limits.
// Reset: the cursor goes home and the result slot empties; then the whole
// screen is cleared one cell per cycle, and in_stall_o stays high until
// that pass ends.
module text_console_port_device_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic        byte_access_i,
  input  logic [15:0] port_address_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        port_hit_o
);

  tcpd_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           back_ready;

  // front: classify and queue
  tcpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (back_ready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .byte_access_i  (byte_access_i),
    .port_address_i (port_address_i),
    .write_data_i   (write_data_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // back: execute against the cell memory
  tcpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .ready_o     (back_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .port_hit_o  (port_hit_o)
  );

endmodule

// ===== design/tcpd_ram.sv =====
module tcpd_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tcpd_front.sv =====
module tcpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic              byte_access_i,
  input  logic [15:0]       port_address_i,
  input  logic [15:0]       write_data_i,
  output logic              cmd_valid_o,
  output tcpd_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  tcpd_pkg::cmd_t                    cmd_new;
  tcpd_pkg::cmd_t                    queue_q [tcpd_pkg::QDepth];
  logic [tcpd_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [tcpd_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [tcpd_pkg::QCntW-1:0]        count_q, count_d;
  logic                              push;
  logic [7:0]                        ch;

  assign ch = write_data_i[7:0];

  // classify the incoming transaction
  always_comb begin
    cmd_new.is_read = opcode_i;
    cmd_new.is_byte = byte_access_i;
    cmd_new.value   = ch;
    cmd_new.colour  = byte_access_i ? 8'h00 : write_data_i[15:8];
    cmd_new.kind    = tcpd_pkg::CMD_NOP;
    priority if (port_address_i == tcpd_pkg::PortCtrl) begin
      cmd_new.kind = tcpd_pkg::CMD_NOP;
    end else if (port_address_i == tcpd_pkg::PortData) begin
      if (opcode_i) begin
        cmd_new.kind = tcpd_pkg::CMD_RD_DATA;
      end else if (ch == tcpd_pkg::ChBackspace) begin
        cmd_new.kind = tcpd_pkg::CMD_BS;
      end else if (ch == tcpd_pkg::ChTab) begin
        cmd_new.kind = tcpd_pkg::CMD_TAB;
      end else if (ch == tcpd_pkg::ChLineFeed) begin
        cmd_new.kind = tcpd_pkg::CMD_LF;
      end else if (ch == tcpd_pkg::ChCarriage) begin
        cmd_new.kind = tcpd_pkg::CMD_CR;
      end else if (ch >= tcpd_pkg::ChSpace && ch < tcpd_pkg::ChDelete) begin
        cmd_new.kind = tcpd_pkg::CMD_DRAW;
      end else begin
        cmd_new.kind = tcpd_pkg::CMD_NOP;
      end
    end else if (port_address_i == tcpd_pkg::PortCol) begin
      cmd_new.kind = opcode_i ? tcpd_pkg::CMD_RD_COL : tcpd_pkg::CMD_SET_COL;
    end else if (port_address_i == tcpd_pkg::PortRow) begin
      cmd_new.kind = opcode_i ? tcpd_pkg::CMD_RD_ROW : tcpd_pkg::CMD_SET_ROW;
    end else begin
      cmd_new.kind = tcpd_pkg::CMD_MISS;
    end
  end

  // queue control
  assign in_stall_o  = (count_q == tcpd_pkg::QCntW'(tcpd_pkg::QDepth)) || !en_i;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tcpd_pkg::QPtrW'(tcpd_pkg::QDepth - 1)) ? '0
               : wr_ptr_q + tcpd_pkg::QPtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == tcpd_pkg::QPtrW'(tcpd_pkg::QDepth - 1)) ? '0
               : rd_ptr_q + tcpd_pkg::QPtrW'(1);
    end
    unique case ({push, cmd_pop_i})
      2'b10:   count_d = count_q + tcpd_pkg::QCntW'(1);
      2'b01:   count_d = count_q - tcpd_pkg::QCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== design/tcpd_back.sv =====
module tcpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tcpd_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       read_data_o,
  output logic              port_hit_o
);

  tcpd_pkg::st_e                     state_q, state_d;
  logic [tcpd_pkg::ColW-1:0]         col_q, col_d;
  logic [tcpd_pkg::RowW-1:0]         row_q, row_d;
  logic [tcpd_pkg::AddrW-1:0]        cnt_q, cnt_d;
  logic [tcpd_pkg::TabW-1:0]         tab_q, tab_d;
  logic                              out_valid_q, out_valid_d;
  logic [15:0]                       out_data_q, out_data_d;
  logic                              out_hit_q, out_hit_d;
  logic                              rd_byte_q, rd_byte_d;

  logic                              out_free;
  logic                              pop;
  logic                              wrap;
  logic [tcpd_pkg::RowW-1:0]         row_next;
  logic [tcpd_pkg::AddrW-1:0]        row_base;
  logic [tcpd_pkg::AddrW-1:0]        cell_idx;
  logic                              init_last;
  logic                              clear_last;

  logic                              ram_we;
  logic [tcpd_pkg::AddrW-1:0]        ram_waddr;
  logic [tcpd_pkg::CellW-1:0]        ram_wdata;
  logic                              ram_re;
  logic [tcpd_pkg::CellW-1:0]        ram_rdata;

  // cursor arithmetic
  assign wrap       = (col_q == tcpd_pkg::ColW'(tcpd_pkg::Cols - 1));
  assign row_next   = (row_q == tcpd_pkg::RowW'(tcpd_pkg::Rows - 1)) ? '0
                    : row_q + tcpd_pkg::RowW'(1);
  assign row_base   = tcpd_pkg::AddrW'(row_q) * tcpd_pkg::AddrW'(tcpd_pkg::Cols);
  assign cell_idx   = row_base + tcpd_pkg::AddrW'(col_q);
  assign init_last  = (cnt_q == tcpd_pkg::AddrW'(tcpd_pkg::Cells - 1));
  assign clear_last = (cnt_q == tcpd_pkg::AddrW'(tcpd_pkg::Cols - 1));

  // a command is taken only when the result slot is free
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop       = (state_q == tcpd_pkg::ST_IDLE) && cmd_valid_i && out_free;
  assign cmd_pop_o = pop;
  assign ready_o   = (state_q != tcpd_pkg::ST_INIT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcpd_pkg::ST_INIT: begin
        if (init_last) state_d = tcpd_pkg::ST_IDLE;
      end
      tcpd_pkg::ST_IDLE: begin
        if (pop) begin
          unique case (cmd_i.kind)
            tcpd_pkg::CMD_RD_DATA: state_d = tcpd_pkg::ST_READ;
            tcpd_pkg::CMD_TAB:     state_d = tcpd_pkg::ST_TAB;
            tcpd_pkg::CMD_LF:      state_d = tcpd_pkg::ST_CLEAR;
            tcpd_pkg::CMD_DRAW:    state_d = wrap ? tcpd_pkg::ST_CLEAR : tcpd_pkg::ST_IDLE;
            default:               state_d = tcpd_pkg::ST_IDLE;
          endcase
        end
      end
      tcpd_pkg::ST_READ: state_d = tcpd_pkg::ST_IDLE;
      tcpd_pkg::ST_TAB: begin
        priority if (wrap)                         state_d = tcpd_pkg::ST_CLEAR;
        else if (tab_q == tcpd_pkg::TabW'(1))      state_d = tcpd_pkg::ST_IDLE;
        else                                       state_d = tcpd_pkg::ST_TAB;
      end
      tcpd_pkg::ST_CLEAR: begin
        if (clear_last) state_d = (tab_q != '0) ? tcpd_pkg::ST_TAB : tcpd_pkg::ST_IDLE;
      end
      default: state_d = tcpd_pkg::ST_INIT;
    endcase
  end

  // datapath, memory and result slot
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    tab_d       = tab_q;
    rd_byte_d   = rd_byte_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    out_hit_d   = out_hit_q;
    ram_we      = 1'b0;
    ram_waddr   = cell_idx;
    ram_wdata   = {cmd_i.colour, cmd_i.value};
    ram_re      = 1'b0;
    unique case (state_q)
      tcpd_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = tcpd_pkg::BlankCell;
        cnt_d     = init_last ? '0 : cnt_q + tcpd_pkg::AddrW'(1);
      end
      tcpd_pkg::ST_IDLE: begin
        if (pop) begin
          out_valid_d = 1'b1;
          out_data_d  = 16'h0000;
          out_hit_d   = 1'b1;
          rd_byte_d   = cmd_i.is_byte;
          unique case (cmd_i.kind)
            tcpd_pkg::CMD_MISS: begin
              out_hit_d  = 1'b0;
              out_data_d = cmd_i.is_read ? tcpd_pkg::ReadMiss : 16'h0000;
            end
            tcpd_pkg::CMD_RD_DATA: begin
              out_valid_d = 1'b0;
              ram_re      = 1'b1;
            end
            tcpd_pkg::CMD_RD_COL: out_data_d = 16'(col_q);
            tcpd_pkg::CMD_RD_ROW: out_data_d = 16'(row_q);
            tcpd_pkg::CMD_SET_COL: begin
              col_d = (cmd_i.value > 8'(tcpd_pkg::Cols - 1))
                    ? tcpd_pkg::ColW'(tcpd_pkg::Cols - 1) : cmd_i.value[tcpd_pkg::ColW-1:0];
            end
            tcpd_pkg::CMD_SET_ROW: begin
              row_d = (cmd_i.value > 8'(tcpd_pkg::Rows - 1))
                    ? tcpd_pkg::RowW'(tcpd_pkg::Rows - 1) : cmd_i.value[tcpd_pkg::RowW-1:0];
            end
            tcpd_pkg::CMD_BS: begin
              if (col_q != '0) col_d = col_q - tcpd_pkg::ColW'(1);
            end
            tcpd_pkg::CMD_CR: col_d = '0;
            tcpd_pkg::CMD_LF: begin
              row_d = row_next;
              cnt_d = '0;
              tab_d = '0;
            end
            tcpd_pkg::CMD_TAB: tab_d = tcpd_pkg::TabW'(tcpd_pkg::TabLen);
            tcpd_pkg::CMD_DRAW: begin
              ram_we = 1'b1;
              tab_d  = '0;
              if (wrap) begin
                col_d = '0;
                row_d = row_next;
                cnt_d = '0;
              end else begin
                col_d = col_q + tcpd_pkg::ColW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      tcpd_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        out_hit_d   = 1'b1;
        out_data_d  = rd_byte_q ? {8'h00, ram_rdata[7:0]} : ram_rdata;
      end
      tcpd_pkg::ST_TAB: begin
        ram_we    = 1'b1;
        ram_wdata = tcpd_pkg::BlankCell;
        tab_d     = tab_q - tcpd_pkg::TabW'(1);
        if (wrap) begin
          col_d = '0;
          row_d = row_next;
          cnt_d = '0;
        end else begin
          col_d = col_q + tcpd_pkg::ColW'(1);
        end
      end
      tcpd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = row_base + cnt_q;
        ram_wdata = tcpd_pkg::BlankCell;
        cnt_d     = cnt_q + tcpd_pkg::AddrW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcpd_pkg::ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      tab_q       <= tab_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_hit_q  <= out_hit_d;
    rd_byte_q  <= rd_byte_d;
  end

  // character and colour cells, colour in the high byte
  tcpd_ram #(
    .Width (tcpd_pkg::CellW),
    .Depth (tcpd_pkg::Cells)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_idx),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign port_hit_o  = out_hit_q;

endmodule

// ===== design/tcpd_checker.sv =====
`include "text_console_port_device_top_assert.svh"

module tcpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        opcode_i,
  input logic        byte_access_i,
  input logic [15:0] port_address_i,
  input logic [15:0] write_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] read_data_o,
  input logic        port_hit_o
);

  // a stalled result transaction holds
  `TCPD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(port_hit_o), "result changed while stalled")

  // an unknown port reads as all ones or, on a write, zero
  `TCPD_ASSERT(a_miss_value, clk_i, rst_ni, out_valid_o && !port_hit_o |-> read_data_o == 16'hFFFF || read_data_o == 16'h0000, "bad value for unknown port")

  // no transaction is taken or shown on the first edge after reset
  `TCPD_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> in_stall_o && !out_valid_o, "activity right after reset")

endmodule

bind text_console_port_device_top tcpd_checker u_tcpd_checker (.*);

// ===== dv/text_console_port_device_checker.sv =====
module text_console_port_device_checker
  import tcpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        opcode_i,
  input  logic        byte_access_i,
  input  logic [15:0] port_address_i,
  input  logic [15:0] write_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] read_data_i,
  input  logic        port_hit_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] read_data;
    logic        port_hit;
  } console_result_t;

  // shadow copy of the screen and cursor
  logic [7:0]      glyph_mem  [Cells];
  logic [7:0]      colour_mem [Cells];
  logic [ColW-1:0] cur_col;
  logic [RowW-1:0] cur_row;

  console_result_t expected_q[$];
  int              mismatches;
  int              checked;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_q.size();
  assign checked_o    = checked;

  function automatic int cursor_cell();
    int idx;
    idx = int'(cur_row) * Cols + int'(cur_col);
    return (idx < Cells) ? idx : 0;
  endfunction

  // move down one row with wrap, then blank the whole new row
  function automatic void feed_line();
    int base;
    int c;
    cur_row = (int'(cur_row) + 1 >= Rows) ? '0 : cur_row + 1'b1;
    base = int'(cur_row) * Cols;
    for (c = 0; c < Cols; c++) begin
      glyph_mem[base + c]  = ChSpace;
      colour_mem[base + c] = 8'h00;
    end
  endfunction

  // store a cell at the cursor and advance, wrapping into the next line
  function automatic void put_glyph(input logic [7:0] ch, input logic [7:0] colour);
    int idx;
    idx = cursor_cell();
    colour_mem[idx] = colour;
    glyph_mem[idx]  = ch;
    if (int'(cur_col) + 1 >= Cols) begin
      feed_line();
      cur_col = '0;
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endfunction

  // one bus access: update the shadow state and return the expected result
  function automatic console_result_t console_access(input logic        is_read,
                                                     input logic        is_byte,
                                                     input logic [15:0] port,
                                                     input logic [15:0] wdata);
    console_result_t res;
    logic [15:0]     data;
    logic [7:0]      ch;
    logic [7:0]      colour;
    int              idx;
    int              i;
    res.read_data = '0;
    res.port_hit  = 1'b1;
    data   = is_byte ? {8'h00, wdata[7:0]} : wdata;
    ch     = data[7:0];
    colour = data[15:8];
    if (is_read) begin
      case (port)
        PortCtrl: res.read_data = '0;
        PortData: begin
          idx = cursor_cell();
          res.read_data = {is_byte ? 8'h00 : colour_mem[idx], glyph_mem[idx]};
        end
        PortCol: res.read_data = 16'(cur_col);
        PortRow: res.read_data = 16'(cur_row);
        default: begin
          res.port_hit  = 1'b0;
          res.read_data = ReadMiss;
        end
      endcase
    end else begin
      case (port)
        // control port swallows writes
        PortCtrl: ;
        PortData: begin
          if (ch == ChBackspace) begin
            if (cur_col != '0) cur_col = cur_col - 1'b1;
          end else if (ch == ChTab) begin
            for (i = 0; i < TabLen; i++) put_glyph(ChSpace, 8'h00);
          end else if (ch == ChLineFeed) begin
            feed_line();
          end else if (ch == ChCarriage) begin
            cur_col = '0;
          end else if (ch >= ChSpace && ch < ChDelete) begin
            put_glyph(ch, colour);
          end
        end
        PortCol: cur_col = (ch > Cols - 1) ? ColW'(Cols - 1) : ch[ColW-1:0];
        PortRow: cur_row = (ch > Rows - 1) ? RowW'(Rows - 1) : ch[RowW-1:0];
        default: res.port_hit = 1'b0;
      endcase
    end
    return res;
  endfunction

  // compare outgoing transactions, then predict incoming ones
  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t got;
    console_result_t want;
    int              c;
    if (!rst_ni) begin
      for (c = 0; c < Cells; c++) begin
        glyph_mem[c]  = ChSpace;
        colour_mem[c] = 8'h00;
      end
      cur_col = '0;
      cur_row = '0;
      expected_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.read_data = read_data_i;
        got.port_hit  = port_hit_i;
        checked++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result read_data %h port_hit %b",
                   $time, got.read_data, got.port_hit);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch expected %h actual %h",
                     $time, want.read_data, got.read_data);
            mismatches++;
          end
          if (got.port_hit !== want.port_hit) begin
            $display("%0t: port_hit mismatch expected %b actual %b",
                     $time, want.port_hit, got.port_hit);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(console_access(opcode_i, byte_access_i,
                                            port_address_i, write_data_i));
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcpd_pkg::*;

  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;
  localparam logic AccWord = 1'b0;
  localparam logic AccByte = 1'b1;

  localparam int RandomItems   = 450;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 100;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        opcode       = 1'b0;
  logic        byte_access  = 1'b0;
  logic [15:0] port_address = '0;
  logic [15:0] write_data   = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] read_data;
  logic        port_hit;

  int mismatches;
  int pending;
  int checked;

  int sent          = 0;
  int reads_sent    = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int idle_cycles   = 0;
  bit draining      = 1'b0;

  text_console_port_device_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .byte_access_i (byte_access),
    .port_address_i(port_address),
    .write_data_i  (write_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data),
    .port_hit_o    (port_hit)
  );

  text_console_port_device_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .byte_access_i (byte_access),
    .port_address_i(port_address),
    .write_data_i  (write_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_i   (read_data),
    .port_hit_i    (port_hit),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // drive one access and wait for its transaction; gaps fall between bursts
  task automatic send_access(input logic op, input logic byt,
                             input logic [15:0] port, input logic [15:0] data);
    opcode       <= op;
    byte_access  <= byt;
    port_address <= port;
    write_data   <= data;
    in_valid     <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    sent++;
    if (op == OpRead) reads_sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 10);
    end
  endtask

  // place a cursor, draw, step back and read the cell
  task automatic probe_cell();
    logic [15:0] col_v;
    logic [15:0] row_v;
    logic [15:0] glyph;
    col_v = 16'($urandom_range(0, 65535));
    row_v = 16'($urandom_range(0, 65535));
    glyph = 16'($urandom_range(0, 65535));
    col_v[7:0] = 8'($urandom_range(0, Cols - 1));
    row_v[7:0] = 8'($urandom_range(0, Rows - 1));
    glyph[7:0] = 8'($urandom_range(ChSpace, ChDelete - 1));
    send_access(OpWrite, 1'($urandom_range(0, 1)), PortCol, col_v);
    send_access(OpWrite, 1'($urandom_range(0, 1)), PortRow, row_v);
    send_access(OpWrite, 1'($urandom_range(0, 1)), PortData, glyph);
    send_access(OpWrite, AccWord, PortData, {8'($urandom_range(0, 255)), ChBackspace});
    send_access(OpRead, 1'($urandom_range(0, 1)), PortData, 16'($urandom_range(0, 65535)));
  endtask

  // one random access, mostly on the console ports
  task automatic random_access();
    int          pick;
    logic [15:0] data;
    logic [15:0] port;
    logic        byt;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    data = 16'($urandom_range(0, 65535));
    byt  = 1'($urandom_range(0, 1));
    if (pick < 12) begin
      probe_cell();
    end else if (pick < 42) begin
      data[7:0] = 8'($urandom_range(ChSpace, ChDelete - 1));
      send_access(OpWrite, byt, PortData, data);
    end else if (pick < 54) begin
      case ($urandom_range(0, 5))
        0:       code = ChBackspace;
        1:       code = ChTab;
        2:       code = ChLineFeed;
        3:       code = ChCarriage;
        default: code = 8'($urandom_range(0, 255));
      endcase
      data[7:0] = code;
      send_access(OpWrite, byt, PortData, data);
    end else if (pick < 68) begin
      send_access(OpRead, byt, PortData, data);
    end else if (pick < 76) begin
      port = ($urandom_range(0, 1) == 1) ? PortCol : PortRow;
      if ($urandom_range(0, 1) == 1) data[7:0] = 8'($urandom_range(0, Cols));
      send_access(OpWrite, byt, port, data);
    end else if (pick < 84) begin
      port = ($urandom_range(0, 1) == 1) ? PortCol : PortRow;
      send_access(OpRead, byt, port, data);
    end else if (pick < 90) begin
      send_access(1'($urandom_range(0, 1)), byt, PortCtrl, data);
    end else begin
      // near the port window or anywhere in the space
      port = ($urandom_range(0, 3) == 0) ? PortCtrl - 16'd4 + 16'($urandom_range(0, 11))
                                         : 16'($urandom_range(0, 65535));
      send_access(1'($urandom_range(0, 1)), byt, port, data);
    end
  endtask

  // receiver stall pattern with occasional long hold-offs
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (draining) begin
        out_stall <= 1'b0;
      end else if (holds_served < hold_requests) begin
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        holds_served++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int directed;
    int n;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // screen and cursor right after reset
    send_access(OpRead,  AccWord, PortData, 16'h0000);
    send_access(OpRead,  AccByte, PortCol,  16'hFFFF);
    send_access(OpRead,  AccWord, PortRow,  16'h0000);
    send_access(OpRead,  AccWord, PortCtrl, 16'h0000);
    send_access(OpWrite, AccWord, PortCtrl, 16'hFFFF);
    // unknown ports at both ends of the space and next to the window
    send_access(OpRead,  AccWord, 16'h0000, 16'h0000);
    send_access(OpWrite, AccByte, 16'hFFFF, 16'hFFFF);
    send_access(OpRead,  AccByte, PortCtrl - 16'd1, 16'h0000);
    send_access(OpRead,  AccWord, PortRow + 16'd1,  16'h0000);
    // clamp both cursor registers to the far corner
    send_access(OpWrite, AccWord, PortCol, 16'hFFFF);
    send_access(OpWrite, AccByte, PortRow, 16'hFFFF);
    send_access(OpRead,  AccWord, PortCol, 16'h0000);
    send_access(OpRead,  AccWord, PortRow, 16'h0000);
    // draw in the last cell, wrapping to the top row
    send_access(OpWrite, AccWord, PortData, {8'hFF, ChDelete - 8'd1});
    send_access(OpRead,  AccWord, PortRow, 16'h0000);
    // byte draw drops the colour; backspace twice holds at column zero
    send_access(OpWrite, AccByte, PortData, 16'hA541);
    send_access(OpWrite, AccWord, PortData, {8'hFF, ChBackspace});
    send_access(OpRead,  AccWord, PortData, 16'h0000);
    send_access(OpWrite, AccByte, PortData, {8'h00, ChBackspace});
    // tab, line feed, carriage return
    send_access(OpWrite, AccWord, PortData, {8'h5A, ChTab});
    send_access(OpRead,  AccWord, PortCol, 16'h0000);
    send_access(OpWrite, AccWord, PortData, {8'hFF, ChLineFeed});
    send_access(OpWrite, AccByte, PortData, {8'h00, ChCarriage});
    // codes with no effect
    send_access(OpWrite, AccWord, PortData, {8'hFF, ChDelete});
    send_access(OpWrite, AccWord, PortData, 16'h8000);
    send_access(OpRead,  AccWord, PortData, 16'h0000);
    directed = sent;

    // random traffic with two long receiver hold-offs along the way
    n = 0;
    while (sent < directed + RandomItems) begin
      if ((hold_requests == 0 && n >= 120) || (hold_requests == 1 && n >= 320)) begin
        hold_requests++;
        burst_left = 40;
      end
      random_access();
      n++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    draining = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d accesses (%0d reads, %0d directed) over data, cursor, control",
             sent, reads_sent, directed);
    $display("and unknown ports; %0d results checked, %0d receiver hold-offs of %0d cycles",
             checked, holds_served, HoldCycles);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
